// ----- rtl/sha256_stream_hasher_core_defines.svh -----
`ifndef SHA256_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_STREAM_HASHER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SHS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/shs_pkg.sv -----
package shs_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [0:7]  hash_t;
    typedef word_t [0:15] block_t;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic        last_word;
    } shs_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } shs_out_t;

    // commands from the sequencer to the compression engine
    typedef struct packed {
        logic start;
        logic reinit;
    } shs_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PACK,
        ST_PAD,
        ST_LEN,
        ST_WAIT,
        ST_EMIT
    } shs_state_t;

    localparam logic [2:0] MAX_BYTES = 3'd4;
    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [2:0] LAST_DIGEST = 3'd7;
    localparam logic [5:0] LAST_ROUND  = 6'd63;

    localparam hash_t HASH_IV = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t [0:63] ROUND_K = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// ----- rtl/shs_compress.sv -----
module shs_compress (
    input  logic             clk,
    input  logic             rst_n,
    input  shs_pkg::shs_cmd_t cmd,
    input  shs_pkg::block_t  block,
    output shs_pkg::hash_t   hash,
    output logic             done
);
    import shs_pkg::*;

    function automatic word_t big_sig0(input word_t x);
        big_sig0 = ((x >> 2) | (x << 30)) ^ ((x >> 13) | (x << 19)) ^ ((x >> 22) | (x << 10));
    endfunction

    function automatic word_t big_sig1(input word_t x);
        big_sig1 = ((x >> 6) | (x << 26)) ^ ((x >> 11) | (x << 21)) ^ ((x >> 25) | (x << 7));
    endfunction

    function automatic word_t small_sig0(input word_t x);
        small_sig0 = ((x >> 7) | (x << 25)) ^ ((x >> 18) | (x << 14)) ^ (x >> 3);
    endfunction

    function automatic word_t small_sig1(input word_t x);
        small_sig1 = ((x >> 17) | (x << 15)) ^ ((x >> 19) | (x << 13)) ^ (x >> 10);
    endfunction

    hash_t      hash_reg, hash_next;
    hash_t      v_reg, v_next;
    block_t     w_reg, w_next;
    logic [5:0] round_reg, round_next;
    logic       run_reg, run_next;
    logic       add_reg, add_next;
    logic       done_reg;

    word_t t_one, t_two, w_new, choose, major;

    always_comb
    begin
        choose = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        major  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t_one  = v_reg[7] + big_sig1(v_reg[4]) + choose + ROUND_K[round_reg] + w_reg[0];
        t_two  = big_sig0(v_reg[0]) + major;
        // rolling 16-word schedule window, w_reg[0] is the current round's word
        w_new  = small_sig1(w_reg[14]) + w_reg[9] + small_sig0(w_reg[1]) + w_reg[0];

        hash_next  = hash_reg;
        v_next     = v_reg;
        w_next     = w_reg;
        round_next = round_reg;
        run_next   = run_reg;
        add_next   = add_reg;

        if (cmd.start)
        begin
            v_next     = hash_reg;
            w_next     = block;
            round_next = '0;
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            v_next = '{t_one + t_two, v_reg[0], v_reg[1], v_reg[2],
                       v_reg[3] + t_one, v_reg[4], v_reg[5], v_reg[6]};
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15] = w_new;
            round_next = round_reg + 6'd1;
            if (round_reg == LAST_ROUND)
            begin
                run_next = 1'b0;
                add_next = 1'b1;
            end
        end
        else if (add_reg)
        begin
            // feed-forward into the chaining value
            for (int i = 0; i < 8; i++)
            begin
                hash_next[i] = hash_reg[i] + v_reg[i];
            end
            add_next = 1'b0;
        end

        if (cmd.reinit)
        begin
            hash_next = HASH_IV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= HASH_IV;
            round_reg <= '0;
            run_reg   <= 1'b0;
            add_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            hash_reg  <= hash_next;
            round_reg <= round_next;
            run_reg   <= run_next;
            add_reg   <= add_next;
            done_reg  <= add_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        w_reg <= w_next;
    end

    assign hash = hash_reg;
    assign done = done_reg;

endmodule

// ----- rtl/sha256_stream_hasher_core.sv -----
// sha-256 over a byte stream fed as 32-bit big-endian words
// each word is taken, then its valid bytes are packed one at a time; each filled 64-byte block
// then goes through compression (64 rounds, one per cycle in the shared round unit, feed-forward, handback)
// last word: padding, one or two blocks, then eight digest transfers, 1 per cycle unstalled
// reset (async, active low): hash state to the initial values, buffer and count to zero
module sha256_stream_hasher_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             word_valid,
    output logic             word_ready,
    input  shs_pkg::shs_in_t word_data,
    output logic             digest_valid,
    input  logic             digest_ready,
    output shs_pkg::shs_out_t digest_data
);
    import shs_pkg::*;

    shs_state_t   state_reg, state_next;
    shs_state_t   ret_reg, ret_next;
    logic [31:0]  word_reg, word_next;
    logic [2:0]   nb_reg, nb_next;
    logic         last_reg, last_next;
    logic [2:0]   idx_reg, idx_next;
    logic [60:0]  count_reg, count_next;
    block_t       buffer_reg, buffer_next;
    logic         out_valid_reg, out_valid_next;
    shs_out_t     out_reg, out_next;

    shs_cmd_t     cmd;
    block_t       block;
    hash_t        hash;
    logic         done;

    block_t       buf_w;
    logic [7:0]   byte_val;
    logic         place;
    logic [5:0]   pos;
    logic [63:0]  bit_len;
    logic [60:0]  count_inc;

    shs_compress u_compress (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .block (block),
        .hash  (hash),
        .done  (done)
    );

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        word_next      = word_reg;
        nb_next        = nb_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg & ~digest_ready;
        out_next       = out_reg;
        cmd            = '0;
        place          = 1'b0;
        byte_val       = word_reg[8'd31 - {idx_reg[1:0], 3'b000} -: 8];
        pos            = count_reg[5:0];
        bit_len        = {count_reg, 3'b000};
        count_inc      = count_reg + 61'd1;
        word_ready     = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (word_valid)
                begin
                    word_next  = word_data.data_word;
                    nb_next    = (word_data.valid_bytes > MAX_BYTES) ? MAX_BYTES
                                                                     : word_data.valid_bytes;
                    last_next  = word_data.last_word;
                    idx_next   = '0;
                    state_next = ST_PACK;
                end
            end
            ST_PACK:
            begin
                if (idx_reg < nb_reg)
                begin
                    place      = 1'b1;
                    count_next = count_inc;
                    idx_next   = idx_reg + 3'd1;
                    // this byte completes the block
                    if (count_inc[5:0] == 6'd0)
                    begin
                        cmd.start  = 1'b1;
                        ret_next   = ST_PACK;
                        state_next = ST_WAIT;
                    end
                end
                else if (last_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                place    = 1'b1;
                byte_val = PAD_BYTE;
                if (pos >= LEN_POS)
                begin
                    // no room left for the length, it goes in an extra block
                    cmd.start  = 1'b1;
                    ret_next   = ST_LEN;
                    state_next = ST_WAIT;
                end
                else
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                cmd.start  = 1'b1;
                ret_next   = ST_EMIT;
                idx_next   = '0;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (done)
                begin
                    state_next = ret_reg;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || digest_ready)
                begin
                    out_valid_next       = 1'b1;
                    out_next.digest_word = hash[idx_reg];
                    out_next.digest_last = (idx_reg == LAST_DIGEST);
                    idx_next             = idx_reg + 3'd1;
                    if (idx_reg == LAST_DIGEST)
                    begin
                        cmd.reinit = 1'b1;
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // the buffer is zero at the write position, so an or places the byte
        buf_w = buffer_reg;
        if (place)
        begin
            buf_w[pos[5:2]] = buffer_reg[pos[5:2]]
                            | ({24'd0, byte_val} << {~pos[1:0], 3'b000});
        end

        block = buf_w;
        if (state_reg == ST_LEN)
        begin
            block[14] = bit_len[63:32];
            block[15] = bit_len[31:0];
        end

        buffer_next = cmd.start ? '0 : buf_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            buffer_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            buffer_reg    <= buffer_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        nb_reg   <= nb_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

    assign digest_valid = out_valid_reg;
    assign digest_data  = out_reg;

endmodule

// ----- rtl/shs_checker.sv -----
`include "sha256_stream_hasher_core_defines.svh"

module shs_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              word_valid,
    input logic              word_ready,
    input shs_pkg::shs_in_t  word_data,
    input logic              digest_valid,
    input logic              digest_ready,
    input shs_pkg::shs_out_t digest_data
);
    import shs_pkg::*;

    logic word_xfer;
    logic digest_stall;
    logic digest_early;

    assign word_xfer    = word_valid && word_ready;
    assign digest_stall = digest_valid && !digest_ready;
    // a digest word other than the last one means the digest is still being sent
    assign digest_early = digest_valid && !digest_data.digest_last;

    `SHS_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, word_xfer, !word_ready, "ready after transfer")
    `SHS_ASSERT_NEXT(a_digest_hold, clk, rst_n, digest_stall, digest_valid && $stable(digest_data), "digest changed while stalled")
    `SHS_ASSERT_NOW(a_no_input_mid_digest, clk, rst_n, digest_early, !word_ready, "input taken mid digest")

endmodule

bind sha256_stream_hasher_core shs_checker u_shs_checker (.*);

// ----- sim/sha256_stream_hasher_core_tb.sv -----
module sha256_stream_hasher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned RANDOM_ITEMS  = 85;
    localparam int unsigned DRAIN_CYCLES  = 20;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned WORD_BYTES    = 4;

    localparam logic [0:7][31:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] SHA_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                word_valid   = 1'b0;
    logic                word_ready;
    shs_pkg::shs_in_t    word_data    = '0;
    logic                digest_valid;
    logic                digest_ready = 1'b0;
    shs_pkg::shs_out_t   digest_data;

    // predictor state
    logic [31:0] chain_h [8];
    logic [31:0] blk_words [16];
    logic [60:0] msg_bytes;

    shs_pkg::shs_out_t pending_digests [$];
    shs_pkg::shs_out_t due_digest;

    int unsigned mismatch_count = 0;
    int unsigned burst_left     = 0;
    int unsigned random_items   = 0;
    int unsigned cycle_count    = 0;
    logic [15:0] stall_pattern  = 16'hffff;
    logic [5:0]  stall_phase    = '0;

    sha256_stream_hasher_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_valid   (word_valid),
        .word_ready   (word_ready),
        .word_data    (word_data),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest_data  (digest_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic sha_model_restart();
        for (int i = 0; i < 8; i++)
            chain_h[i] = SHA_IV[i];
        for (int i = 0; i < 16; i++)
            blk_words[i] = '0;
        msg_bytes = '0;
    endtask

    task automatic model_run_block();
        logic [31:0] sched [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] s0, s1, t1, t2;
        for (int i = 0; i < 16; i++)
            sched[i] = blk_words[i];
        for (int i = 16; i < 64; i++)
        begin
            s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
            s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
            sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
        end
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + SHA_K[i] + sched[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
        for (int i = 0; i < 16; i++)
            blk_words[i] = '0;
    endtask

    // drops one byte at the current fill position, big-endian inside the word
    task automatic stash_byte(logic [7:0] b);
        logic [5:0] pos;
        pos = msg_bytes[5:0];
        blk_words[pos[5:2]] |= {24'h0, b} << (24 - 8 * int'(pos[1:0]));
    endtask

    task automatic sha_model_absorb(shs_pkg::shs_in_t item);
        int unsigned       nb;
        logic [63:0]       bit_len;
        shs_pkg::shs_out_t want;
        nb = (item.valid_bytes > WORD_BYTES) ? WORD_BYTES : item.valid_bytes;
        for (int i = 0; i < nb; i++)
        begin
            stash_byte(item.data_word[31 - 8 * i -: 8]);
            msg_bytes = msg_bytes + 61'd1;
            if (msg_bytes[5:0] == 6'd0)
                model_run_block();
        end
        if (item.last_word)
        begin
            bit_len = {msg_bytes, 3'b000};
            stash_byte(8'h80);
            // length no longer fits behind the pad, spill into one more block
            if (msg_bytes[5:0] >= 6'd56)
                model_run_block();
            blk_words[14] = bit_len[63:32];
            blk_words[15] = bit_len[31:0];
            model_run_block();
            for (int k = 0; k < 8; k++)
            begin
                want.digest_word = chain_h[k];
                want.digest_last = (k == 7);
                pending_digests.push_back(want);
            end
            sha_model_restart();
        end
    endtask

    task automatic note_mismatch(string what, shs_pkg::shs_out_t want, shs_pkg::shs_out_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("digest mismatch (%s): expected word %h last %b, got word %h last %b",
                     what, want.digest_word, want.digest_last,
                     got.digest_word, got.digest_last);
    endtask

    task automatic send_word(logic [31:0] data, logic [2:0] nb, logic last);
        shs_pkg::shs_in_t item;
        int unsigned      gap;
        item.data_word   = data;
        item.valid_bytes = nb;
        item.last_word   = last;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                word_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        word_valid <= 1'b1;
        word_data  <= item;
        @(posedge clk);
        while (!word_ready)
            @(posedge clk);
        sha_model_absorb(item);
    endtask

    // random content, random word fill, exactly n_bytes of message
    task automatic send_message(int unsigned n_bytes);
        int unsigned left;
        int unsigned pick;
        logic [2:0]  nb;
        left = n_bytes;
        while (left > WORD_BYTES)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 5)
                nb = 3'd4;
            else if (pick == 6)
                nb = 3'($urandom_range(5, 7));
            else if (pick == 7)
                nb = 3'($urandom_range(1, 3));
            else if (pick == 8)
                nb = 3'd0;
            else
                nb = 3'($urandom_range(1, 4));
            send_word($urandom, nb, 1'b0);
            random_items++;
            left -= (nb > WORD_BYTES) ? WORD_BYTES : nb;
        end
        nb = (left == WORD_BYTES) ? 3'($urandom_range(4, 7)) : 3'(left);
        send_word($urandom, nb, 1'b1);
        random_items++;
    endtask

    task automatic test_empty_message();
        send_word(32'h0000_0000, 3'd0, 1'b1);
        send_word(32'hffff_ffff, 3'd0, 1'b1);
    endtask

    task automatic test_field_extremes();
        send_word(32'h0000_0000, 3'd4, 1'b1);
        send_word(32'hffff_ffff, 3'd4, 1'b1);
        send_word(32'h6162_63ff, 3'd3, 1'b1);
    endtask

    task automatic test_short_words_packed();
        send_word(32'h1122_3344, 3'd1, 1'b0);
        send_word(32'h5566_7788, 3'd2, 1'b0);
        send_word(32'h99aa_bbcc, 3'd3, 1'b0);
        send_word(32'hffff_ffff, 3'd0, 1'b0);
        send_word(32'h0000_0000, 3'd4, 1'b0);
        send_word(32'hdead_beef, 3'd2, 1'b1);
    endtask

    task automatic test_oversized_valid_count();
        send_word(32'hffff_ffff, 3'd5, 1'b0);
        send_word(32'ha5a5_a5a5, 3'd6, 1'b0);
        send_word(32'h0000_0000, 3'd7, 1'b0);
        send_word(32'h1234_5678, 3'd7, 1'b1);
    endtask

    // lengths around the point where the length field spills into an extra block
    task automatic test_pad_boundaries();
        int unsigned lens [4] = '{55, 56, 63, 64};
        foreach (lens[i])
            send_message(lens[i]);
    endtask

    task automatic test_random_messages();
        int unsigned boundary_lens [8] = '{55, 56, 57, 60, 63, 64, 119, 120};
        int unsigned mode;
        while (random_items < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 3);
            case (mode)
                0: send_message($urandom_range(0, 8));
                1: send_message($urandom_range(9, 40));
                2: send_message(boundary_lens[$urandom_range(0, 7)]);
                default: send_message($urandom_range(41, 130));
            endcase
        end
    endtask

    // receiver: rotating stall pattern, swapped each time the phase counter wraps, sometimes always ready
    always @(posedge clk)
    begin
        if (stall_phase == 6'd0)
            stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hffff
                                                        : (16'($urandom) | 16'h0001);
        digest_ready <= stall_pattern[stall_phase[3:0]];
        stall_phase  <= stall_phase + 6'd1;
    end

    always @(posedge clk)
    begin
        if (rst_n && digest_valid && digest_ready)
        begin
            if (pending_digests.size() == 0)
                note_mismatch("unexpected transfer", '0, digest_data);
            else
            begin
                due_digest = pending_digests.pop_front();
                if (due_digest.digest_word !== digest_data.digest_word
                    || due_digest.digest_last !== digest_data.digest_last)
                    note_mismatch("field", due_digest, digest_data);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        sha_model_restart();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_message();
        test_field_extremes();
        test_short_words_packed();
        test_oversized_valid_count();
        random_items = 0;
        test_pad_boundaries();
        test_random_messages();
        word_valid <= 1'b0;
        while (pending_digests.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_digests.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
